### rtl/linear_phase_dc_blocker_defines.svh
// Assertion macros used by the linear-phase DC blocker engine
`ifndef LINEAR_PHASE_DC_BLOCKER_DEFINES_SVH
`define LINEAR_PHASE_DC_BLOCKER_DEFINES_SVH
`ifndef SYNTHESIS
`define LPDCB_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lpdcb: implication check failed");
`define LPDCB_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lpdcb: next-cycle check failed");
`else
`define LPDCB_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define LPDCB_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

### rtl/lpdcb_pkg.sv
// Package: constants, types and helper functions of the linear-phase DC blocker
package lpdcb_pkg;

    localparam int MAX_LENGTH     = 1024;
    localparam int SAMPLE_BITS    = 24;
    localparam int NUM_STAGES     = 4;
    localparam int DEFAULT_LENGTH = 128;
    localparam int MIN_LENGTH     = 4;
    localparam int RECIP_FRAC     = 24;

    localparam int LEN_W      = $clog2(MAX_LENGTH) + 1;
    localparam int STAGE_AW   = $clog2(MAX_LENGTH);
    localparam int LONG_DEPTH = 2 * (MAX_LENGTH - 1);
    localparam int LONG_AW    = $clog2(LONG_DEPTH);
    localparam int STAGE_BW   = $clog2(NUM_STAGES);
    localparam int BANK_AW    = STAGE_BW + STAGE_AW;
    localparam int BANK_DEPTH = NUM_STAGES * MAX_LENGTH;
    localparam int SUM_W      = SAMPLE_BITS + STAGE_AW + 1;
    localparam int RECIP_W    = RECIP_FRAC + 1;
    localparam int MUL_LO_W   = (SUM_W + 1) / 2;
    localparam int MUL_A_W    = MUL_LO_W + 1;
    localparam int MUL_B_W    = RECIP_W + 1;
    localparam int MUL_P_W    = MUL_A_W + MUL_B_W;
    localparam int ACC_W      = SUM_W + RECIP_W + 1;
    localparam int DIV_CNT_W  = $clog2(RECIP_W);
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = LEN_W;

    localparam logic [RECIP_W-1:0] RECIP_RESET =
        RECIP_W'(((2 ** RECIP_FRAC) + (DEFAULT_LENGTH / 2)) / DEFAULT_LENGTH);

    typedef logic signed [SAMPLE_BITS-1:0] sample_t;
    typedef logic [LEN_W-1:0]              len_t;
    typedef logic [RECIP_W-1:0]            recip_t;
    typedef logic signed [SUM_W-1:0]       sum_t;
    typedef logic signed [ACC_W-1:0]       acc_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FILTER_LENGTH = 1'b0,
        CFG_KEEP_STATE    = 1'b1
    } cfg_index_t;

    typedef struct packed {
        logic start;
        logic clear;
        logic res_take;
    } eng_ctrl_t;

    typedef struct packed {
        logic idle;
        logic res_valid;
    } eng_stat_t;

    function automatic len_t eff_length(input len_t req);
        len_t n;
        n = req;
        if (req == '0)
        begin
            n = len_t'(DEFAULT_LENGTH);
        end
        else if (req < len_t'(MIN_LENGTH))
        begin
            n = len_t'(MIN_LENGTH);
        end
        else if (req > len_t'(MAX_LENGTH))
        begin
            n = len_t'(MAX_LENGTH);
        end
        return n;
    endfunction

    function automatic sample_t sat_sample(input acc_t v);
        acc_t hi;
        acc_t lo;
        hi = (acc_t'(1) <<< (SAMPLE_BITS - 1)) - acc_t'(1);
        lo = -hi - acc_t'(1);
        if (v > hi)
        begin
            return hi[SAMPLE_BITS-1:0];
        end
        else if (v < lo)
        begin
            return lo[SAMPLE_BITS-1:0];
        end
        return v[SAMPLE_BITS-1:0];
    endfunction

endpackage

### rtl/lpdcb_recip_div.sv
// Restoring divider that forms the rounded reciprocal 2^24/N, one quotient bit per cycle
module lpdcb_recip_div (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  lpdcb_pkg::len_t       len,
    output logic                  busy,
    output lpdcb_pkg::recip_t     recip
);

    logic                                busy_reg;
    logic                                busy_next;
    logic [lpdcb_pkg::DIV_CNT_W-1:0]     cnt_reg;
    logic [lpdcb_pkg::DIV_CNT_W-1:0]     cnt_next;
    lpdcb_pkg::recip_t                   recip_reg;
    lpdcb_pkg::recip_t                   recip_next;
    lpdcb_pkg::len_t                     rem_reg;
    lpdcb_pkg::len_t                     rem_next;
    lpdcb_pkg::recip_t                   num_reg;
    lpdcb_pkg::recip_t                   num_next;
    lpdcb_pkg::recip_t                   quo_reg;
    lpdcb_pkg::recip_t                   quo_next;
    lpdcb_pkg::len_t                     div_reg;
    lpdcb_pkg::len_t                     div_next;
    logic [lpdcb_pkg::LEN_W:0]           trial;
    logic                                qbit;

    always_comb
    begin
        busy_next  = busy_reg;
        cnt_next   = cnt_reg;
        recip_next = recip_reg;
        rem_next   = rem_reg;
        num_next   = num_reg;
        quo_next   = quo_reg;
        div_next   = div_reg;
        trial      = {rem_reg, num_reg[lpdcb_pkg::RECIP_W-1]};
        qbit       = (trial >= {1'b0, div_reg});
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = lpdcb_pkg::DIV_CNT_W'(lpdcb_pkg::RECIP_W - 1);
            rem_next  = '0;
            quo_next  = '0;
            div_next  = len;
            num_next  = (lpdcb_pkg::recip_t'(1) << lpdcb_pkg::RECIP_FRAC)
                        + lpdcb_pkg::recip_t'(len >> 1);
        end
        else if (busy_reg)
        begin
            rem_next = qbit ? lpdcb_pkg::LEN_W'(trial - {1'b0, div_reg})
                            : lpdcb_pkg::LEN_W'(trial);
            quo_next = {quo_reg[lpdcb_pkg::RECIP_W-2:0], qbit};
            num_next = num_reg << 1;
            if (cnt_reg == '0)
            begin
                busy_next  = 1'b0;
                recip_next = {quo_reg[lpdcb_pkg::RECIP_W-2:0], qbit};
            end
            else
            begin
                cnt_next = cnt_reg - lpdcb_pkg::DIV_CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            cnt_reg   <= '0;
            recip_reg <= lpdcb_pkg::RECIP_RESET;
        end
        else
        begin
            busy_reg  <= busy_next;
            cnt_reg   <= cnt_next;
            recip_reg <= recip_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        num_reg <= num_next;
        quo_reg <= quo_next;
        div_reg <= div_next;
    end

    assign busy  = busy_reg;
    assign recip = recip_reg;

endmodule

### rtl/lpdcb_engine.sv
// Sample engine: delay-line memories, running sums and the shared scaling multiplier
`include "linear_phase_dc_blocker_defines.svh"

module lpdcb_engine (
    input  logic                  clk,
    input  logic                  rst_n,
    input  lpdcb_pkg::eng_ctrl_t  ctrl,
    input  lpdcb_pkg::sample_t    sample,
    input  lpdcb_pkg::len_t       eff_len,
    input  lpdcb_pkg::recip_t     recip,
    output lpdcb_pkg::eng_stat_t  stat,
    output lpdcb_pkg::sample_t    result
);

    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_SUM  = 6'b000010,
        ST_MLO  = 6'b000100,
        ST_MHI  = 6'b001000,
        ST_RND  = 6'b010000,
        ST_DONE = 6'b100000
    } state_t;

    localparam logic [lpdcb_pkg::STAGE_BW-1:0] STAGE_LAST =
        lpdcb_pkg::STAGE_BW'(lpdcb_pkg::NUM_STAGES - 1);

    lpdcb_pkg::sample_t long_mem [lpdcb_pkg::LONG_DEPTH];
    lpdcb_pkg::sample_t bank_mem [lpdcb_pkg::BANK_DEPTH];

    state_t                               state_reg;
    state_t                               state_next;
    logic [lpdcb_pkg::STAGE_BW-1:0]       stage_reg;
    logic [lpdcb_pkg::STAGE_BW-1:0]       stage_next;
    logic [lpdcb_pkg::STAGE_BW-1:0]       stage_inc;
    logic [lpdcb_pkg::LONG_AW-1:0]        lp_reg;
    logic [lpdcb_pkg::LONG_AW-1:0]        lp_next;
    logic [lpdcb_pkg::STAGE_AW-1:0]       sp_reg;
    logic [lpdcb_pkg::STAGE_AW-1:0]       sp_next;
    logic                                 long_full_reg;
    logic                                 long_full_next;
    logic                                 stage_full_reg;
    logic                                 stage_full_next;
    lpdcb_pkg::sum_t                      sums_reg [lpdcb_pkg::NUM_STAGES];

    lpdcb_pkg::sample_t                   x_reg;
    lpdcb_pkg::sample_t                   delayed_reg;
    lpdcb_pkg::sum_t                      sum_reg;
    lpdcb_pkg::acc_t                      acc_reg;
    lpdcb_pkg::sample_t                   long_rd_reg;
    lpdcb_pkg::sample_t                   bank_rd_reg;

    lpdcb_pkg::len_t                      len_m1;
    logic [lpdcb_pkg::LONG_AW-1:0]        long_size;
    logic [lpdcb_pkg::LONG_AW:0]          lp_inc;
    lpdcb_pkg::len_t                      sp_inc;
    logic                                 long_we;
    logic                                 long_re;
    logic                                 bank_we;
    logic                                 bank_re;
    logic [lpdcb_pkg::BANK_AW-1:0]        bank_raddr;
    lpdcb_pkg::sample_t                   old_val;
    lpdcb_pkg::sum_t                      sum_new;
    logic signed [lpdcb_pkg::MUL_A_W-1:0] mul_a;
    logic signed [lpdcb_pkg::MUL_B_W-1:0] mul_b;
    logic signed [lpdcb_pkg::MUL_P_W-1:0] mul_p;
    lpdcb_pkg::acc_t                      acc_next;
    lpdcb_pkg::acc_t                      rnd;
    lpdcb_pkg::acc_t                      rnd_shift;
    lpdcb_pkg::sample_t                   stage_y;

    assign len_m1    = eff_len - lpdcb_pkg::len_t'(1);
    assign long_size = lpdcb_pkg::LONG_AW'({len_m1, 1'b0});
    assign lp_inc    = {1'b0, lp_reg} + (lpdcb_pkg::LONG_AW + 1)'(1);
    assign sp_inc    = lpdcb_pkg::LEN_W'(sp_reg) + lpdcb_pkg::len_t'(1);
    assign stage_inc = stage_reg + lpdcb_pkg::STAGE_BW'(1);

    assign long_re    = (state_reg == ST_IDLE) && ctrl.start;
    assign long_we    = (state_reg == ST_SUM) && (stage_reg == '0);
    assign bank_re    = long_re || (state_reg == ST_SUM);
    assign bank_we    = (state_reg == ST_SUM);
    assign bank_raddr = (state_reg == ST_IDLE) ? {lpdcb_pkg::STAGE_BW'(0), sp_reg}
                                               : {stage_inc, sp_reg};

    always_ff @(posedge clk)
    begin
        if (long_we)
        begin
            long_mem[lp_reg] <= x_reg;
        end
        if (long_re)
        begin
            long_rd_reg <= long_mem[lp_reg];
        end
    end

    always_ff @(posedge clk)
    begin
        if (bank_we)
        begin
            bank_mem[{stage_reg, sp_reg}] <= x_reg;
        end
        if (bank_re)
        begin
            bank_rd_reg <= bank_mem[bank_raddr];
        end
    end

    // Entries not yet written since the last clear read as zero
    assign old_val = stage_full_reg ? bank_rd_reg : '0;
    assign sum_new = sums_reg[stage_reg] + lpdcb_pkg::sum_t'(x_reg)
                     - lpdcb_pkg::sum_t'(old_val);

    assign mul_a = (state_reg == ST_MHI)
                   ? lpdcb_pkg::MUL_A_W'($signed(sum_reg[lpdcb_pkg::SUM_W-1:lpdcb_pkg::MUL_LO_W]))
                   : $signed({1'b0, sum_reg[lpdcb_pkg::MUL_LO_W-1:0]});
    assign mul_b = $signed({1'b0, recip});
    assign mul_p = mul_a * mul_b;

    always_comb
    begin
        acc_next = acc_reg;
        case (state_reg)
            ST_MLO:  acc_next = lpdcb_pkg::acc_t'(mul_p);
            ST_MHI:  acc_next = acc_reg + (lpdcb_pkg::acc_t'(mul_p) <<< lpdcb_pkg::MUL_LO_W);
            default: acc_next = acc_reg;
        endcase
    end

    assign rnd       = acc_reg + (lpdcb_pkg::acc_t'(1) <<< (lpdcb_pkg::RECIP_FRAC - 1));
    assign rnd_shift = rnd >>> lpdcb_pkg::RECIP_FRAC;
    assign stage_y   = lpdcb_pkg::sat_sample(rnd_shift);

    always_comb
    begin
        state_next      = state_reg;
        stage_next      = stage_reg;
        lp_next         = lp_reg;
        sp_next         = sp_reg;
        long_full_next  = long_full_reg;
        stage_full_next = stage_full_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (ctrl.start)
                begin
                    state_next = ST_SUM;
                    stage_next = '0;
                end
            end
            ST_SUM:  state_next = ST_MLO;
            ST_MLO:  state_next = ST_MHI;
            ST_MHI:  state_next = ST_RND;
            ST_RND:
            begin
                if (stage_reg == STAGE_LAST)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    stage_next = stage_inc;
                    state_next = ST_SUM;
                end
            end
            ST_DONE:
            begin
                if (ctrl.res_take)
                begin
                    state_next = ST_IDLE;
                    if (lp_inc >= {1'b0, long_size})
                    begin
                        lp_next        = '0;
                        long_full_next = 1'b1;
                    end
                    else
                    begin
                        lp_next = lp_inc[lpdcb_pkg::LONG_AW-1:0];
                    end
                    if (sp_inc >= eff_len)
                    begin
                        sp_next         = '0;
                        stage_full_next = 1'b1;
                    end
                    else
                    begin
                        sp_next = sp_inc[lpdcb_pkg::STAGE_AW-1:0];
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
        if (ctrl.clear)
        begin
            lp_next         = '0;
            sp_next         = '0;
            long_full_next  = 1'b0;
            stage_full_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            stage_reg      <= '0;
            lp_reg         <= '0;
            sp_reg         <= '0;
            long_full_reg  <= 1'b0;
            stage_full_reg <= 1'b0;
            for (int i = 0; i < lpdcb_pkg::NUM_STAGES; i++)
            begin
                sums_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg      <= state_next;
            stage_reg      <= stage_next;
            lp_reg         <= lp_next;
            sp_reg         <= sp_next;
            long_full_reg  <= long_full_next;
            stage_full_reg <= stage_full_next;
            if (ctrl.clear)
            begin
                for (int i = 0; i < lpdcb_pkg::NUM_STAGES; i++)
                begin
                    sums_reg[i] <= '0;
                end
            end
            else if (state_reg == ST_SUM)
            begin
                sums_reg[stage_reg] <= sum_new;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        if ((state_reg == ST_IDLE) && ctrl.start)
        begin
            x_reg <= sample;
        end
        else if (state_reg == ST_RND)
        begin
            x_reg <= stage_y;
        end
        if (long_we)
        begin
            delayed_reg <= long_full_reg ? long_rd_reg : '0;
        end
        if (state_reg == ST_SUM)
        begin
            sum_reg <= sum_new;
        end
    end

    assign stat.idle      = (state_reg == ST_IDLE);
    assign stat.res_valid = (state_reg == ST_DONE);
    assign result = lpdcb_pkg::sat_sample(lpdcb_pkg::acc_t'(delayed_reg)
                                          - lpdcb_pkg::acc_t'(x_reg));

    `LPDCB_ASSERT_IMPL(a_start_only_idle, clk, rst_n, ctrl.start, state_reg == ST_IDLE)
    `LPDCB_ASSERT_IMPL(a_long_ptr_range, clk, rst_n, 1'b1, lp_reg < long_size)
    `LPDCB_ASSERT_IMPL(a_stage_ptr_range, clk, rst_n, 1'b1, sp_inc <= eff_len)
    `LPDCB_ASSERT_NEXT(a_last_stage_done, clk, rst_n, (state_reg == ST_RND) && (stage_reg == STAGE_LAST), state_reg == ST_DONE)
    `LPDCB_ASSERT_NEXT(a_take_to_idle, clk, rst_n, ctrl.res_take, state_reg == ST_IDLE)

endmodule

### rtl/linear_phase_dc_blocker.sv
// Each accepted sample runs four cascade stages on one shared multiplier (sum, low and high
// multiply, round); sample_in_ready stays low until the output register takes the result.
// A filter_length write holds sample_in_ready low while the reciprocal divider runs.
// Reset (rst_n, asynchronous, active low): N = 128, keep_state = 0, sums and pointers cleared.
// Delay lines need no clearing pass: fill flags make unwritten entries read as zero.
module linear_phase_dc_blocker (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                sample_in_valid,
    output logic                                sample_in_ready,
    input  lpdcb_pkg::sample_t                  sample_in,
    output logic                                sample_out_valid,
    input  logic                                sample_out_ready,
    output lpdcb_pkg::sample_t                  sample_out,
    input  logic                                cfg_we,
    input  logic [lpdcb_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [lpdcb_pkg::CFG_DATA_W-1:0]    cfg_data
);

    lpdcb_pkg::len_t       eff_len_reg;
    lpdcb_pkg::len_t       eff_len_next;
    logic                  keep_reg;
    logic                  keep_next;
    logic                  out_valid_reg;
    logic                  out_valid_next;
    lpdcb_pkg::sample_t    out_data_reg;

    lpdcb_pkg::len_t       new_len;
    logic                  len_wr;
    logic                  div_busy;
    lpdcb_pkg::recip_t     recip;
    lpdcb_pkg::eng_ctrl_t  ctrl;
    lpdcb_pkg::eng_stat_t  stat;
    lpdcb_pkg::sample_t    eng_result;

    assign new_len = lpdcb_pkg::eff_length(cfg_data);
    assign len_wr  = cfg_we && (lpdcb_pkg::cfg_index_t'(cfg_index) == lpdcb_pkg::CFG_FILTER_LENGTH);

    always_comb
    begin
        eff_len_next = eff_len_reg;
        keep_next    = keep_reg;
        if (cfg_we)
        begin
            case (lpdcb_pkg::cfg_index_t'(cfg_index))
                lpdcb_pkg::CFG_FILTER_LENGTH: eff_len_next = new_len;
                lpdcb_pkg::CFG_KEEP_STATE:    keep_next    = cfg_data[0];
                default:                      eff_len_next = eff_len_reg;
            endcase
        end
    end

    assign sample_in_ready = stat.idle && !div_busy;
    assign ctrl.start      = sample_in_valid && sample_in_ready;
    assign ctrl.clear      = len_wr && (!keep_reg || (new_len != eff_len_reg));
    assign ctrl.res_take   = stat.res_valid && (!out_valid_reg || sample_out_ready);

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (ctrl.res_take)
        begin
            out_valid_next = 1'b1;
        end
        else if (sample_out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            eff_len_reg   <= lpdcb_pkg::len_t'(lpdcb_pkg::DEFAULT_LENGTH);
            keep_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            eff_len_reg   <= eff_len_next;
            keep_reg      <= keep_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.res_take)
        begin
            out_data_reg <= eng_result;
        end
    end

    lpdcb_recip_div u_recip_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (len_wr),
        .len   (new_len),
        .busy  (div_busy),
        .recip (recip)
    );

    lpdcb_engine u_engine (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (ctrl),
        .sample  (sample_in),
        .eff_len (eff_len_reg),
        .recip   (recip),
        .stat    (stat),
        .result  (eng_result)
    );

    assign sample_out_valid = out_valid_reg;
    assign sample_out       = out_data_reg;

endmodule

### tb/tb.sv
// Self-checking testbench for linear_phase_dc_blocker: sample prediction, random flow control
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import lpdcb_pkg::*;

    localparam sample_t SMAX = 24'sh7FFFFF;
    localparam sample_t SMIN = 24'sh800000;
    localparam int NUM_PHASES = 15;
    localparam int PRESSURE_PHASE = 5;
    localparam int unsigned HOLD_CYCLES = 300;

    class dc_blocker_checker;
        sample_t     long_line [LONG_DEPTH];
        sample_t     stage_line [NUM_STAGES][MAX_LENGTH];
        longint      stage_sum [NUM_STAGES];
        int unsigned long_pos;
        int unsigned stage_pos;
        int unsigned length_n;
        longint      recip;
        bit          keep_on_rewrite;
        sample_t     filtered_due [$];
        int unsigned mismatches;
        int unsigned compared;

        function new();
            mismatches = 0;
            compared = 0;
            keep_on_rewrite = 1'b0;
            clear_history();
            set_length(DEFAULT_LENGTH);
        endfunction

        function void clear_history();
            foreach (long_line[i])
            begin
                long_line[i] = '0;
            end
            foreach (stage_line[i, k])
            begin
                stage_line[i][k] = '0;
            end
            foreach (stage_sum[i])
            begin
                stage_sum[i] = 0;
            end
            long_pos = 0;
            stage_pos = 0;
        endfunction

        function void set_length(int unsigned n);
            length_n = n;
            recip = ((longint'(1) << RECIP_FRAC) + longint'(n / 2)) / longint'(n);
        endfunction

        function int unsigned effective_n(int unsigned req);
            if (req == 0)
            begin
                return DEFAULT_LENGTH;
            end
            if (req < MIN_LENGTH)
            begin
                return MIN_LENGTH;
            end
            if (req > MAX_LENGTH)
            begin
                return MAX_LENGTH;
            end
            return req;
        endfunction

        function longint clip(longint v);
            longint top;
            top = (longint'(1) << (SAMPLE_BITS - 1)) - 1;
            if (v > top)
            begin
                return top;
            end
            if (v < -top - 1)
            begin
                return -top - 1;
            end
            return v;
        endfunction

        function void write_reg(cfg_index_t idx, int unsigned value);
            int unsigned n;
            case (idx)
                CFG_FILTER_LENGTH:
                begin
                    n = effective_n(value & ((1 << CFG_DATA_W) - 1));
                    if (!keep_on_rewrite || n != length_n)
                    begin
                        clear_history();
                    end
                    set_length(n);
                end
                CFG_KEEP_STATE:
                begin
                    keep_on_rewrite = value[0];
                end
                default:
                begin
                end
            endcase
        endfunction

        function void note_sample(sample_t s);
            longint      x;
            longint      delayed;
            longint      old;
            int unsigned long_size;
            long_size = 2 * (length_n - 1);
            if (long_pos >= long_size)
            begin
                long_pos = 0;
            end
            if (stage_pos >= length_n)
            begin
                stage_pos = 0;
            end
            x = s;
            delayed = long_line[long_pos];
            long_line[long_pos] = s;
            for (int j = 0; j < NUM_STAGES; j++)
            begin
                old = stage_line[j][stage_pos];
                stage_line[j][stage_pos] = sample_t'(x);
                stage_sum[j] = stage_sum[j] + x - old;
                x = clip((stage_sum[j] * recip + (longint'(1) << (RECIP_FRAC - 1)))
                         >>> RECIP_FRAC);
            end
            filtered_due.push_back(sample_t'(clip(delayed - x)));
            long_pos = (long_pos + 1 >= long_size) ? 0 : long_pos + 1;
            stage_pos = (stage_pos + 1 >= length_n) ? 0 : stage_pos + 1;
        endfunction

        function void check_sample(sample_t got);
            sample_t want;
            if (filtered_due.size() == 0)
            begin
                $error("sample_out: transfer with no expected value, actual %0d", got);
                mismatches++;
                return;
            end
            want = filtered_due.pop_front();
            compared++;
            if (got !== want)
            begin
                $error("sample_out mismatch: expected %0d, actual %0d", want, got);
                mismatches++;
            end
        endfunction
    endclass

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 sample_in_valid;
    logic                 sample_in_ready;
    sample_t              sample_in;
    logic                 sample_out_valid;
    logic                 sample_out_ready;
    sample_t              sample_out;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    dc_blocker_checker sb = new();

    bit          in_idle_on = 1'b1;
    bit          out_idle_on = 1'b1;
    bit          hold_off_req = 1'b0;
    int unsigned hold_left = 0;
    int unsigned stall_left = 0;
    int unsigned run_left = 0;
    sample_t     run_value = '0;

    linear_phase_dc_blocker dut (.*);

    always #4 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (sample_in_valid && sample_in_ready)
            begin
                sb.note_sample(sample_in);
            end
            if (sample_out_valid && sample_out_ready)
            begin
                sb.check_sample(sample_out);
            end
        end
    end

    initial
    begin
        sample_out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_left == 0 && hold_off_req)
            begin
                hold_off_req = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                sample_out_ready <= 1'b0;
                hold_left--;
            end
            else if (stall_left > 0)
            begin
                sample_out_ready <= 1'b0;
                stall_left--;
            end
            else
            begin
                sample_out_ready <= 1'b1;
                if (out_idle_on && $urandom_range(0, 5) == 0)
                begin
                    stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60)
                                                               : $urandom_range(1, 3);
                end
            end
        end
    end

    initial
    begin
        #10_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    function automatic int unsigned pick_gap();
        int unsigned r;
        if (!in_idle_on)
        begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 60)
        begin
            return 0;
        end
        if (r < 90)
        begin
            return $urandom_range(1, 3);
        end
        if (r < 97)
        begin
            return $urandom_range(4, 15);
        end
        return $urandom_range(25, 70);
    endfunction

    function automatic sample_t next_sample();
        int unsigned r;
        if (run_left > 0)
        begin
            run_left--;
            return run_value;
        end
        r = $urandom_range(0, 99);
        if (r < 20)
        begin
            run_left = $urandom_range(3, 40);
            if ($urandom_range(0, 1) == 1)
            begin
                run_value = ($urandom_range(0, 1) == 1) ? SMAX : SMIN;
            end
            else
            begin
                run_value = sample_t'($urandom);
            end
            return run_value;
        end
        if (r < 60)
        begin
            return sample_t'($urandom);
        end
        if (r < 75)
        begin
            case ($urandom_range(0, 3))
                0: return SMAX;
                1: return SMIN;
                2: return '0;
                default: return '1;
            endcase
        end
        return sample_t'(int'($urandom_range(0, 2000)) - 1000);
    endfunction

    task automatic send_sample(input sample_t value);
        int unsigned gap;
        gap = pick_gap();
        @(negedge clk);
        if (gap > 0)
        begin
            sample_in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        sample_in_valid <= 1'b1;
        sample_in <= value;
        do
            @(posedge clk);
        while (!sample_in_ready);
    endtask

    task automatic stop_sending();
        @(negedge clk);
        sample_in_valid <= 1'b0;
    endtask

    task automatic drain();
        while (sb.filtered_due.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (24) @(posedge clk);
    endtask

    task automatic program_reg(input cfg_index_t idx, input int unsigned value);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= CFG_DATA_W'(value);
        @(negedge clk);
        cfg_we <= 1'b0;
        sb.write_reg(idx, value);
    endtask

    initial
    begin
        int      phase_len [NUM_PHASES] =
            '{6, 6, 2, 3, 3, 0, 1025, 2047, 17, -1, 0, 5, 9, 1024, 4};
        int      phase_keep [NUM_PHASES] =
            '{0, 1, 1, 1, 0, 0, 0, 1, 0, 1, 0, 0, 1, 0, 0};
        int      phase_items [NUM_PHASES] =
            '{120, 110, 110, 90, 90, 150, 60, 60, 120, 80, 140, 120, 120, 60, 110};
        sample_t opening [$];

        rst_n = 1'b0;
        sample_in_valid = 1'b0;
        sample_in = '0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        phase_len[10] = int'($urandom_range(4, 64));
        phase_keep[10] = int'($urandom_range(0, 1));
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        opening = '{SMAX, SMIN, 24'sh000000, 24'shFFFFFF, 24'sh000001,
                    24'sh555555, 24'shAAAAAA, SMAX};
        foreach (opening[i])
        begin
            send_sample(opening[i]);
        end
        stop_sending();
        drain();

        // isolated negative spike inside a positive run drives the output into saturation
        program_reg(CFG_KEEP_STATE, 0);
        program_reg(CFG_FILTER_LENGTH, 1);
        repeat (10) send_sample(SMAX);
        send_sample(SMIN);
        repeat (6) send_sample(SMAX);
        stop_sending();
        drain();

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            in_idle_on = (p % 4 != 3);
            out_idle_on = (p % 4 != 3) && (p % 4 != 1);
            program_reg(CFG_KEEP_STATE, phase_keep[p]);
            if (phase_len[p] >= 0)
            begin
                program_reg(CFG_FILTER_LENGTH, phase_len[p]);
            end
            for (int i = 0; i < phase_items[p]; i++)
            begin
                if (p == PRESSURE_PHASE && i == 12)
                begin
                    hold_off_req = 1'b1;
                end
                send_sample(next_sample());
            end
            stop_sending();
            drain();
        end

        $display("Checked %0d filtered samples across %0d length settings, N from 4 to 1024.",
                 sb.compared, NUM_PHASES + 1);
        $display("Covered kept and cleared state on rewrites, saturation and a %0d-cycle hold.",
                 HOLD_CYCLES);
        if (sb.mismatches == 0 && sb.filtered_due.size() == 0)
        begin
            $display("Simulation PASSED");
        end
        else
        begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

### linear_phase_dc_blocker.f
+incdir+rtl
rtl/lpdcb_pkg.sv
rtl/lpdcb_recip_div.sv
rtl/lpdcb_engine.sv
rtl/linear_phase_dc_blocker.sv
tb/tb.sv
